@@ sv/windowed_moving_average_assert.svh @@
// Assertion macros for the checker file of the moving average block.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define WMA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define WMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/wma_pkg.sv @@
package wma_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int SAMPLE_BITS  = 16;
   localparam int ADDR_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   // window_size and fill_count are fixed 7-bit fields
   localparam int COUNT_BITS   = 7;
   // wide enough for WINDOW_DEPTH full-scale samples
   localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int STEP_BITS    = $clog2(SUM_BITS + 1);

   localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(8);

endpackage

@@ sv/windowed_moving_average.sv @@
// Windowed moving average over a ring of up to WINDOW_DEPTH samples.
// Path: the input transfer enters S_UPDATE, then SUM_BITS = 22 restoring divide
//    steps in S_DIV, then S_DONE loads the output register once it is free.
// Flow: one item at a time, as req_ready is high only in S_IDLE; the serial divider
//    yields one quotient bit per cycle; a bypass item goes straight to S_DONE.
// Reset: window_size returns to 8, position, count and sum clear; no ring clear.
module windowed_moving_average import wma_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_average,
   output logic        [COUNT_BITS-1:0]  rsp_fill_count,
   // configuration
   input  logic                          csr_write_enable,
   input  logic        [COUNT_BITS-1:0]  csr_write_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_UPDATE = 4'b0010,
      S_DIV    = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   // Control state
   state_type                    state_ff, state_in;
   logic [COUNT_BITS-1:0]        window_ff, window_in;
   logic [ADDR_BITS-1:0]         wr_pos_ff, wr_pos_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Per-item payload
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [ADDR_BITS-1:0]          pos_ff, pos_in;
   logic [COUNT_BITS-1:0]         divisor_ff, divisor_in;
   logic [SUM_BITS-1:0]           quo_ff, quo_in;
   logic [COUNT_BITS-1:0]         rem_ff, rem_in;
   logic                          neg_ff, neg_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [COUNT_BITS-1:0]         fill_ff, fill_in;

   // Ring memory: one write port, one registered read port
   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_rdata_ff;
   logic                   ring_re;
   logic [ADDR_BITS-1:0]   ring_raddr;
   logic                   ring_we;

   // Datapath helpers
   logic [COUNT_BITS-1:0]       win_eff;
   logic [ADDR_BITS-1:0]        pos_eff;
   logic [ADDR_BITS-1:0]        pos_next;
   logic                        req_xfer;
   logic                        slot_free;
   logic                        ring_full;
   logic signed [SUM_BITS-1:0]  old_term;
   logic signed [SUM_BITS-1:0]  new_sum;
   logic [SUM_BITS-1:0]         new_mag;
   logic [COUNT_BITS:0]         shifted;
   logic [COUNT_BITS+1:0]       diff;
   logic [SUM_BITS-1:0]         quo_signed;

   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Saturate oversized windows at the ring depth
   assign win_eff = (32'(window_ff) > WINDOW_DEPTH) ? COUNT_BITS'(WINDOW_DEPTH) : window_ff;

   // Wrap a stray position before it is used
   assign pos_eff  = (32'(wr_pos_ff) >= 32'(win_eff)) ? '0 : wr_pos_ff;
   assign pos_next = (32'(pos_ff) + 32'd1 >= 32'(win_eff)) ? '0 : pos_ff + 1'b1;

   // Read the entry about to be overwritten at the transfer; the data lands in
   // S_UPDATE. The previous write finished before S_IDLE, so no forwarding.
   assign ring_re    = req_xfer;
   assign ring_raddr = pos_eff;
   assign ring_we    = (state_ff == S_UPDATE);

   // Sum update: add the new sample, drop the overwritten one once full
   assign ring_full = (count_ff >= win_eff);
   assign old_term  = ring_full ? SUM_BITS'($signed(ring_rdata_ff)) : '0;
   assign new_sum   = sum_ff + SUM_BITS'(sample_ff) - old_term;
   assign new_mag   = new_sum[SUM_BITS-1] ? SUM_BITS'(-new_sum) : SUM_BITS'(new_sum);

   // One restoring divide step: shift in the next dividend bit, try subtract
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};

   // Restore the sign; truncation toward zero falls out of dividing magnitudes
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      wr_pos_in    = wr_pos_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      pos_in       = pos_ff;
      divisor_in   = divisor_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      avg_in       = avg_ff;
      fill_in      = fill_ff;

      // Drop the output once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               sample_in = req_sample;
               pos_in    = pos_eff;
               if (win_eff == '0) begin
                  // Bypass: pass the sample through, leave the state alone
                  quo_in     = SUM_BITS'(req_sample);
                  neg_in     = 1'b0;
                  divisor_in = '0;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            sum_in     = new_sum;
            count_in   = ring_full ? win_eff : count_ff + 1'b1;
            wr_pos_in  = pos_next;
            divisor_in = ring_full ? win_eff : count_ff + 1'b1;
            quo_in     = new_mag;
            neg_in     = new_sum[SUM_BITS-1];
            rem_in     = '0;
            step_in    = STEP_BITS'(SUM_BITS);
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (diff[COUNT_BITS+1]) begin
               rem_in = shifted[COUNT_BITS-1:0];
            end else begin
               rem_in = diff[COUNT_BITS-1:0];
            end
            quo_in  = {quo_ff[SUM_BITS-2:0], ~diff[COUNT_BITS+1]};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold the result until the output register is free
            if (slot_free) begin
               avg_in       = quo_signed[SAMPLE_BITS-1:0];
               fill_in      = divisor_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A window write clears the running state; it must arrive only while idle, which the block does not enforce
      if (csr_write_enable) begin
         window_in = csr_write_data;
         wr_pos_in = '0;
         count_in  = '0;
         sum_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WINDOW_RESET;
         wr_pos_ff    <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         wr_pos_ff    <= wr_pos_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      pos_ff     <= pos_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      avg_ff     <= avg_in;
      fill_ff    <= fill_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[pos_ff] <= sample_ff;
      end
      if (ring_re) begin
         ring_rdata_ff <= ring_mem[ring_raddr];
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = avg_ff;
   assign rsp_fill_count = fill_ff;

endmodule

@@ sv/wma_checker.sv @@
`include "windowed_moving_average_assert.svh"

module wma_checker import wma_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [SAMPLE_BITS-1:0] req_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_average,
   input logic        [COUNT_BITS-1:0]  rsp_fill_count,
   input logic                          csr_write_enable,
   input logic        [COUNT_BITS-1:0]  csr_write_data
);

   // Hold a stalled result steady
   `WMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_average) && $stable(rsp_fill_count), "stalled result changed")

   // One item at a time: busy right after an input transfer
   `WMA_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_valid && req_ready, !req_ready, "input taken while busy")

   // Never report more samples than the ring holds
   `WMA_ASSERT_IMP(a_fill_bound, clock, reset, rsp_valid, 32'(rsp_fill_count) <= WINDOW_DEPTH, "fill count above ring depth")

   // Reset empties the output and readies the input
   `WMA_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid && req_ready, "reset left output or input busy")

endmodule

bind windowed_moving_average wma_checker u_wma_checker (.*);

@@ tb/sv/tb_windowed_moving_average.sv @@
`timescale 1ns / 1ps

module tb_windowed_moving_average;
   import wma_pkg::*;

   // ---------------------------------------------------------------------
   // Run shape
   // ---------------------------------------------------------------------
   localparam int RANDOM_ITEMS    = 1630;  // on top of the directed table
   localparam int IDLE_PCT        = 27;    // idle cycles per hundred, each side
   localparam int HOLD_OFF_CYCLES = 400;   // one long receiver stall
   localparam int DRAIN_CYCLES    = 30;    // settling wait after the final drain
   localparam int DIRECTED_ROWS   = 27;

   // One result transfer: the mean and how many samples went into it.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] average;
      logic [COUNT_BITS-1:0]  fill_count;
   } mean_type;

   typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_type;

   // One row of the directed table. A row with checked set carries its
   // expected mean; every other sample row is checked against the predictor.
   typedef struct packed {
      row_kind_type           kind;
      logic [SAMPLE_BITS-1:0] value;
      logic                   checked;
      logic [SAMPLE_BITS-1:0] average;
      logic [COUNT_BITS-1:0]  fill_count;
   } stim_row_type;

   // How the samples of one random run are drawn.
   typedef enum int {
      FILL_RANDOM, FILL_TOP, FILL_BOTTOM, FILL_NEAR_ZERO, FILL_SWING
   } fill_style_type;

   // ---------------------------------------------------------------------
   // Block ports; the inputs driven here are known from time zero
   // ---------------------------------------------------------------------
   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample       = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_average;
   logic        [COUNT_BITS-1:0]  rsp_fill_count;
   logic                          csr_write_enable = 1'b0;
   logic        [COUNT_BITS-1:0]  csr_write_data   = '0;

   windowed_moving_average dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_average      (rsp_average),
      .rsp_fill_count   (rsp_fill_count),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 4 ns period: high half, then low half.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared run state
   // ---------------------------------------------------------------------
   mean_type pending_means [$];   // expected means, oldest first
   int    sender_idle_pct   = IDLE_PCT;
   int    receiver_idle_pct = IDLE_PCT;
   bit    stall_receiver    = 1'b0;
   int    failure_count     = 0;
   int    samples_sent      = 0;
   int    results_checked   = 0;
   int    window_writes     = 0;

   // Mirror of the averaging state, kept at the block's own widths.
   logic        [COUNT_BITS-1:0]  window_size_q = WINDOW_RESET;
   logic signed [SAMPLE_BITS-1:0] history [WINDOW_DEPTH];
   logic        [ADDR_BITS-1:0]   slot          = '0;
   logic        [COUNT_BITS-1:0]  depth_used    = '0;
   logic signed [SUM_BITS-1:0]    total         = '0;

   // Push one sample into the mirrored ring and return the mean it yields.
   function automatic mean_type advance_average(input logic [SAMPLE_BITS-1:0] raw);
      logic signed [SAMPLE_BITS-1:0] sample;
      logic signed [SUM_BITS-1:0]    quotient;
      int                            span;
      int                            next_slot;
      mean_type                      result;
      sample = raw;
      // Anything above the ring depth saturates to the full ring.
      span = (window_size_q > WINDOW_DEPTH) ? WINDOW_DEPTH : window_size_q;
      if (span == 0) begin
         // Bypass: echo the sample, touch no state.
         result.average    = raw;
         result.fill_count = '0;
         return result;
      end
      if (slot >= span) slot = '0;
      // Once full, drop the oldest sample before adding the new one.
      if (depth_used >= span) begin
         total      = total - history[slot];
         depth_used = COUNT_BITS'(span);
      end else begin
         depth_used = depth_used + 1'b1;
      end
      history[slot] = sample;
      total         = total + sample;
      next_slot     = slot + 1;
      if (next_slot >= span) next_slot = 0;
      slot = next_slot[ADDR_BITS-1:0];
      // Signed divide truncates toward zero, as required.
      quotient          = total / $signed({1'b0, depth_used});
      result.average    = quotient[SAMPLE_BITS-1:0];
      result.fill_count = depth_used;
      return result;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] draw_sample(input fill_style_type style);
      int offset;
      case (style)
         FILL_TOP:       return ($urandom_range(0, 5) == 0) ? SAMPLE_BITS'($urandom) : 16'h7FFF;
         FILL_BOTTOM:    return ($urandom_range(0, 5) == 0) ? SAMPLE_BITS'($urandom) : 16'h8000;
         FILL_NEAR_ZERO: begin
            offset = int'($urandom_range(0, 400)) - 200;
            return offset[SAMPLE_BITS-1:0];
         end
         FILL_SWING:     return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         default:        return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------

   // Offer one sample and hold it until the transfer. Called at a rising
   // edge; returns at the edge of the transfer with req_valid still high, so
   // a back-to-back sample goes out without a dip.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] value,
                              input logic use_table, input mean_type table_mean);
      mean_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      // Advance the mirror even for table rows so later rows line up.
      predicted = advance_average(value);
      pending_means.push_back(use_table ? table_mean : predicted);
      samples_sent++;
   endtask

   // Drop valid and wait until every expected mean has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_means.size() != 0);
   endtask

   // Write window_size with the block idle, then clear the mirror the same way.
   task automatic write_window(input logic [COUNT_BITS-1:0] setting);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_size_q = setting;
      slot          = '0;
      depth_used    = '0;
      total         = '0;
      window_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Receiver side: random backpressure, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : receiver
      while (reset) @(posedge clock);
      forever begin
         if (stall_receiver) begin
            // Hold ready low long enough for the block to back up its input.
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            stall_receiver = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Result check: compare each transfer against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_averages
      mean_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_means.size() == 0) begin
            failure_count++;
            $display("%0t: result with nothing expected: average %0d fill_count %0d",
                     $time, rsp_average, rsp_fill_count);
         end else begin
            want = pending_means.pop_front();
            results_checked++;
            if (rsp_average !== want.average) begin
               failure_count++;
               $display("%0t: average mismatch: expected %0d, actual %0d",
                        $time, $signed(want.average), rsp_average);
            end
            if (rsp_fill_count !== want.fill_count) begin
               failure_count++;
               $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                        $time, want.fill_count, rsp_fill_count);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   stim_row_type directed_rows [DIRECTED_ROWS];

   initial begin : stimulus
      mean_type                table_mean;
      logic [COUNT_BITS-1:0]   setting;
      fill_style_type          style;
      int                      pick;
      int                      run_length;
      int                      random_sent;
      int                      phase;

      // Reset-time window of 8, then bypass, a window of one, an oversized
      // window, truncation of negative means, full-scale negatives, full depth.
      directed_rows = '{
         '{ROW_SAMPLE, 16'd100,       1'b1, 16'd100,        7'd1},
         '{ROW_SAMPLE, 16'h8000,      1'b1, -16'sd16334,    7'd2},
         '{ROW_SAMPLE, 16'h7FFF,      1'b1, 16'd33,         7'd3},
         '{ROW_WINDOW, 16'd0,         1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'h8000,      1'b1, 16'h8000,       7'd0},
         '{ROW_SAMPLE, 16'h7FFF,      1'b1, 16'h7FFF,       7'd0},
         '{ROW_SAMPLE, 16'hFFFF,      1'b1, 16'hFFFF,       7'd0},
         '{ROW_WINDOW, 16'd1,         1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, -16'sd7,       1'b1, -16'sd7,        7'd1},
         '{ROW_SAMPLE, 16'd5,         1'b1, 16'd5,          7'd1},
         '{ROW_WINDOW, 16'd127,       1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'h7FFF,      1'b1, 16'h7FFF,       7'd1},
         '{ROW_SAMPLE, 16'h7FFF,      1'b1, 16'h7FFF,       7'd2},
         '{ROW_SAMPLE, 16'h8000,      1'b0, 16'd0,          7'd0},
         '{ROW_WINDOW, 16'd3,         1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, -16'sd1,       1'b1, -16'sd1,        7'd1},
         '{ROW_SAMPLE, -16'sd2,       1'b1, -16'sd1,        7'd2},
         '{ROW_SAMPLE, 16'd1,         1'b1, 16'd0,          7'd3},
         '{ROW_SAMPLE, 16'd4,         1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'h5A5A,      1'b0, 16'd0,          7'd0},
         '{ROW_WINDOW, 16'd2,         1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'h8000,      1'b1, 16'h8000,       7'd1},
         '{ROW_SAMPLE, 16'h8000,      1'b1, 16'h8000,       7'd2},
         '{ROW_SAMPLE, 16'h8000,      1'b1, 16'h8000,       7'd2},
         '{ROW_WINDOW, 16'd64,        1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'h1234,      1'b0, 16'd0,          7'd0},
         '{ROW_SAMPLE, 16'hEDCB,      1'b0, 16'd0,          7'd0}
      };

      // Hold reset, then release it synchronously.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WINDOW) begin
            write_window(directed_rows[r].value[COUNT_BITS-1:0]);
         end else begin
            table_mean.average    = directed_rows[r].average;
            table_mean.fill_count = directed_rows[r].fill_count;
            send_sample(directed_rows[r].value, directed_rows[r].checked, table_mean);
         end
      end

      // Random runs: each picks a window, then streams samples long enough,
      // most of the time, to fill the ring and wrap it several times.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       setting = 7'd0;
            1:       setting = 7'd1;
            2:       setting = 7'd64;
            3:       setting = 7'd127;
            4:       setting = COUNT_BITS'($urandom_range(65, 126));
            5:       setting = 7'd2;
            default: setting = COUNT_BITS'($urandom_range(2, 63));
         endcase
         write_window(setting);

         pick       = $urandom_range(0, 6);
         style      = (pick > 4) ? FILL_RANDOM : fill_style_type'(pick);
         run_length = $urandom_range(20, 160);

         // Second run: stall the receiver while samples keep coming, so the
         // block backs up and drops req_ready.
         if (phase == 1) begin
            stall_receiver  = 1'b1;
            sender_idle_pct = 0;
            run_length      = 80;
         end
         // Fourth run: a long stretch with no idling on either side.
         if (phase == 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
            run_length        = 250;
         end
         if (phase == 2 && run_length < 40) run_length = 40;

         for (int i = 0; i < run_length && random_sent < RANDOM_ITEMS; i++) begin
            // Third run: pause the sender mid-stream until all means are back.
            if (phase == 2 && i == run_length / 2) drain();
            send_sample(draw_sample(style), 1'b0, '0);
            random_sent++;
         end

         sender_idle_pct   = IDLE_PCT;
         receiver_idle_pct = IDLE_PCT;
         phase++;
      end

      // Let the last means come home, then give the block its latency again.
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d samples across %0d window settings, bypass and oversized included.",
               samples_sent, window_writes);
      $display("Compared %0d averages with %0d mismatching fields.",
               results_checked, failure_count);
      if (failure_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Give up on a hung run well past the slowest legal finish.
   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
